FILE: hdl/crfe_pkg.sv
// ----------------------------------------------------------------------------
// crfe_pkg
// Shared types, codes and defaults for the clipped rectangle fill engine.
// ----------------------------------------------------------------------------
package crfe_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_LAYERS = 4;

    localparam int COORD_W = 9;
    localparam int LAYER_W = 8;
    localparam int BRUSH_W = 10;
    localparam int PIX_W   = 32;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_LAYER_COUNT   = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAX_BRUSH     = 2'd3;

    localparam logic [8:0] RST_CANVAS_WIDTH  = 9'd256;
    localparam logic [8:0] RST_CANVAS_HEIGHT = 9'd256;
    localparam logic [2:0] RST_LAYER_COUNT   = 3'd4;
    localparam logic [9:0] RST_MAX_BRUSH     = 10'd200;

    localparam logic [1:0] MODE_PAINT = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_X     = 3'd1;
    localparam logic [2:0] ST_BAD_Y     = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ST_BAD_LAYER = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  alpha_in;
        logic [9:0]  brush_size;
        logic [7:0]  layer;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } rsp_t;

    // effective canvas settings, already clamped to the store's limits
    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [LAYER_W-1:0] layers;
        logic [BRUSH_W-1:0] max_brush;
    } cfg_t;

endpackage

FILE: hdl/crfe_pixel_mem.sv
// ----------------------------------------------------------------------------
// crfe_pixel_mem
// Single-port pixel RAM with a registered read.
// ----------------------------------------------------------------------------
module crfe_pixel_mem #(
    parameter longint unsigned DEPTH  = 262144,
    parameter int              ADDR_W = 18
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [crfe_pkg::PIX_W-1:0] wdata,
    output logic [crfe_pkg::PIX_W-1:0] rdata
);

    logic [crfe_pkg::PIX_W-1:0] mem_q [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_q[addr];
        end
    end

endmodule

FILE: hdl/crfe_ctrl.sv
// ----------------------------------------------------------------------------
// crfe_ctrl
// Command sequencer: checks a request, walks the clipped square or layer one
// pixel a cycle, issues reads, and holds the response register.
// ----------------------------------------------------------------------------
module crfe_ctrl #(
    parameter int MAX_WIDTH  = crfe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crfe_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_LAYERS = crfe_pkg::DEF_MAX_LAYERS,
    parameter int ADDR_W     = 18
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  crfe_pkg::cfg_t             cfg,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  crfe_pkg::cmd_t             cmd,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output crfe_pkg::rsp_t             rsp,
    output logic                       mem_we,
    output logic                       mem_re,
    output logic [ADDR_W-1:0]          mem_addr,
    output logic [crfe_pkg::PIX_W-1:0] mem_wdata,
    input  logic [crfe_pkg::PIX_W-1:0] mem_rdata
);

    localparam longint unsigned LAYER_WORDS = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam longint unsigned DEPTH       = LAYER_WORDS * longint'(MAX_LAYERS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] LAYER_STEP = ADDR_W'(LAYER_WORDS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_RDREQ = 3'd5;
    localparam logic [2:0] S_RWAIT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam int CW = crfe_pkg::COORD_W;

    logic [2:0]        state_reg, state_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    crfe_pkg::cmd_t             cmd_reg;
    crfe_pkg::rsp_t             rsp_reg;
    logic [2:0]                 status_reg;
    logic [crfe_pkg::PIX_W-1:0] pix_reg;
    logic [ADDR_W-1:0]          layer_base_reg;
    logic [ADDR_W-1:0]          row_off_reg;
    logic [ADDR_W-1:0]          row_addr_reg;
    logic [CW-1:0]              x_reg, x_start_reg, x_end_reg;
    logic [CW-1:0]              y_reg, y_end_reg;
    logic                       empty_reg;

    logic [2:0]    status_c;
    logic          x_ok, y_ok, size_ok, lay_ok;
    logic [CW+1:0] x_sum, y_sum;
    logic [CW-1:0] px_end, py_end;
    logic          go_fill, go_read;
    logic          rsp_slot_free;
    logic [crfe_pkg::PIX_W-1:0] colour;

    assign colour = {cmd_reg.alpha_in, cmd_reg.blue_in, cmd_reg.green_in, cmd_reg.red_in};

    always_comb
    begin
        x_ok    = cmd_reg.pos_x < 16'(cfg.width);
        y_ok    = cmd_reg.pos_y < 16'(cfg.height);
        size_ok = cmd_reg.brush_size <= cfg.max_brush;
        lay_ok  = cmd_reg.layer < cfg.layers;
        status_c = crfe_pkg::ST_OK;
        unique case (cmd_reg.mode)
            crfe_pkg::MODE_PAINT:
            begin
                if (!x_ok)         status_c = crfe_pkg::ST_BAD_X;
                else if (!y_ok)    status_c = crfe_pkg::ST_BAD_Y;
                else if (!size_ok) status_c = crfe_pkg::ST_BAD_SIZE;
                else if (!lay_ok)  status_c = crfe_pkg::ST_BAD_LAYER;
            end
            crfe_pkg::MODE_CLEAR:
            begin
                if (!lay_ok)       status_c = crfe_pkg::ST_BAD_LAYER;
            end
            crfe_pkg::MODE_READ:
            begin
                if (!x_ok)         status_c = crfe_pkg::ST_BAD_X;
                else if (!y_ok)    status_c = crfe_pkg::ST_BAD_Y;
                else if (!lay_ok)  status_c = crfe_pkg::ST_BAD_LAYER;
            end
            default:
            begin
                status_c = crfe_pkg::ST_OK;
            end
        endcase
        x_sum  = (CW+2)'(cmd_reg.pos_x[CW-1:0]) + (CW+2)'(cmd_reg.brush_size);
        y_sum  = (CW+2)'(cmd_reg.pos_y[CW-1:0]) + (CW+2)'(cmd_reg.brush_size);
        px_end = (x_sum > (CW+2)'(cfg.width))  ? cfg.width  : x_sum[CW-1:0];
        py_end = (y_sum > (CW+2)'(cfg.height)) ? cfg.height : y_sum[CW-1:0];
    end

    assign go_fill = (status_reg == crfe_pkg::ST_OK) && !empty_reg &&
                     ((cmd_reg.mode == crfe_pkg::MODE_PAINT) ||
                      (cmd_reg.mode == crfe_pkg::MODE_CLEAR));
    assign go_read = (status_reg == crfe_pkg::ST_OK) && (cmd_reg.mode == crfe_pkg::MODE_READ);
    assign rsp_slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_INIT:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                addr_next = layer_base_reg + row_off_reg + ADDR_W'(x_start_reg);
                if (go_fill)      state_next = S_FILL;
                else if (go_read) state_next = S_RDREQ;
                else              state_next = S_DONE;
            end
            S_FILL:
            begin
                if (x_reg + 1'b1 != x_end_reg)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                else if (y_reg + 1'b1 != y_end_reg)
                begin
                    addr_next = row_addr_reg + ROW_STEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RDREQ:
            begin
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            addr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_SETUP)
        begin
            status_reg     <= status_c;
            pix_reg        <= '0;
            layer_base_reg <= ADDR_W'(cmd_reg.layer) * LAYER_STEP;
            if (cmd_reg.mode == crfe_pkg::MODE_CLEAR)
            begin
                row_off_reg <= '0;
                x_start_reg <= '0;
                x_end_reg   <= cfg.width;
                y_reg       <= '0;
                y_end_reg   <= cfg.height;
                empty_reg   <= (cfg.width == '0) || (cfg.height == '0);
            end
            else
            begin
                row_off_reg <= ADDR_W'(cmd_reg.pos_y[CW-1:0]) * ROW_STEP;
                x_start_reg <= cmd_reg.pos_x[CW-1:0];
                x_end_reg   <= px_end;
                y_reg       <= cmd_reg.pos_y[CW-1:0];
                y_end_reg   <= py_end;
                empty_reg   <= (cmd_reg.brush_size == '0);
            end
        end
        if (state_reg == S_ADDR)
        begin
            row_addr_reg <= addr_next;
            x_reg        <= x_start_reg;
        end
        if (state_reg == S_FILL)
        begin
            if (x_reg + 1'b1 != x_end_reg)
            begin
                x_reg <= x_reg + 1'b1;
            end
            else
            begin
                x_reg        <= x_start_reg;
                y_reg        <= y_reg + 1'b1;
                row_addr_reg <= row_addr_reg + ROW_STEP;
            end
        end
        if (state_reg == S_RWAIT)
        begin
            pix_reg <= mem_rdata;
        end
        if (state_reg == S_DONE && rsp_slot_free)
        begin
            rsp_reg.status    <= status_reg;
            rsp_reg.red_out   <= pix_reg[7:0];
            rsp_reg.green_out <= pix_reg[15:8];
            rsp_reg.blue_out  <= pix_reg[23:16];
            rsp_reg.alpha_out <= pix_reg[31:24];
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign mem_we    = (state_reg == S_INIT) || (state_reg == S_FILL);
    assign mem_re    = (state_reg == S_RDREQ);
    assign mem_addr  = addr_reg;
    assign mem_wdata = (state_reg == S_INIT) ? '0 : colour;

    a_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (status_reg == crfe_pkg::ST_OK))
        else $error("pixel write for a rejected request");

    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> ((x_reg < x_end_reg) && (y_reg < y_end_reg)))
        else $error("fill walked outside the clipped area");

    a_read_mode: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> ((cmd_reg.mode == crfe_pkg::MODE_READ) && (status_reg == crfe_pkg::ST_OK)))
        else $error("memory read outside a valid read request");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside completion");

endmodule

FILE: hdl/clipped_rect_fill_engine_top.sv
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine_top
// Layered RGBA pixel store with clipped square paint, layer clear and read.
//
// Requests enter on cmd (valid/ready); each gives exactly one response on
// rsp (valid/ready) with a status and, for reads, the pixel colour.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// while no request is in flight; the user must keep to this, the block does not enforce it.
// One request is processed at a time by a sequencer that writes one pixel
// per cycle into a single-port RAM:
//   paint: clipped edge_x * clipped edge_y pixels
//   clear: canvas_width * canvas_height pixels of the layer
//   read : one registered RAM read, no pixel written
//   rejected or unused-mode request: no memory access
// After reset the RAM is swept to zero, one word a cycle, over all
// MAX_LAYERS * MAX_WIDTH * MAX_HEIGHT words (262144 by default); cmd_ready
// stays low during the sweep.
// The response sits in an output register; while it waits the next request
// is accepted and processed, and only its completion waits for the slot.
// ----------------------------------------------------------------------------
module clipped_rect_fill_engine_top #(
    parameter int MAX_WIDTH  = crfe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crfe_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_LAYERS = crfe_pkg::DEF_MAX_LAYERS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [crfe_pkg::IDX_W-1:0] cfg_index,
    input  logic [crfe_pkg::CFG_W-1:0] cfg_data,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  crfe_pkg::cmd_t             cmd,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output crfe_pkg::rsp_t             rsp
);

    localparam longint unsigned DEPTH =
        longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) * longint'(MAX_LAYERS);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [8:0] canvas_width_reg;
    logic [8:0] canvas_height_reg;
    logic [2:0] layer_count_reg;
    logic [9:0] max_brush_reg;

    crfe_pkg::cfg_t cfg;

    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_addr;
    logic [crfe_pkg::PIX_W-1:0] mem_wdata;
    logic [crfe_pkg::PIX_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= crfe_pkg::RST_CANVAS_WIDTH;
            canvas_height_reg <= crfe_pkg::RST_CANVAS_HEIGHT;
            layer_count_reg   <= crfe_pkg::RST_LAYER_COUNT;
            max_brush_reg     <= crfe_pkg::RST_MAX_BRUSH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crfe_pkg::REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[8:0];
                crfe_pkg::REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[8:0];
                crfe_pkg::REG_LAYER_COUNT:   layer_count_reg   <= cfg_data[2:0];
                crfe_pkg::REG_MAX_BRUSH:     max_brush_reg     <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // clamp to what the store can hold
    always_comb
    begin
        cfg.width  = (32'(canvas_width_reg) > MAX_WIDTH) ?
                     crfe_pkg::COORD_W'(MAX_WIDTH) : canvas_width_reg;
        cfg.height = (32'(canvas_height_reg) > MAX_HEIGHT) ?
                     crfe_pkg::COORD_W'(MAX_HEIGHT) : canvas_height_reg;
        cfg.layers = (32'(layer_count_reg) > MAX_LAYERS) ?
                     crfe_pkg::LAYER_W'(MAX_LAYERS) : crfe_pkg::LAYER_W'(layer_count_reg);
        cfg.max_brush = max_brush_reg;
    end

    crfe_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_LAYERS (MAX_LAYERS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    crfe_pixel_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
